// ===== rtl/psg_pkg.sv =====
// shared types, register addresses and level tables for the sound generator
`default_nettype none

package psg_pkg;

    // register addresses of a write transaction
    localparam logic [3:0] ADDR_TONE_FINE_A   = 4'd0;
    localparam logic [3:0] ADDR_TONE_COARSE_A = 4'd1;
    localparam logic [3:0] ADDR_TONE_FINE_B   = 4'd2;
    localparam logic [3:0] ADDR_TONE_COARSE_B = 4'd3;
    localparam logic [3:0] ADDR_TONE_FINE_C   = 4'd4;
    localparam logic [3:0] ADDR_TONE_COARSE_C = 4'd5;
    localparam logic [3:0] ADDR_NOISE_PERIOD  = 4'd6;
    localparam logic [3:0] ADDR_MIXER         = 4'd7;
    localparam logic [3:0] ADDR_LEVEL_A       = 4'd8;
    localparam logic [3:0] ADDR_LEVEL_B       = 4'd9;
    localparam logic [3:0] ADDR_LEVEL_C       = 4'd10;
    localparam logic [3:0] ADDR_ENV_LO        = 4'd11;
    localparam logic [3:0] ADDR_ENV_HI        = 4'd12;
    localparam logic [3:0] ADDR_ENV_SHAPE     = 4'd13;

    localparam logic       CMD_TICK  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;

    localparam logic [16:0] NOISE_SEED = 17'h10000;
    localparam logic [4:0]  STEP_MAX_LONG  = 5'h1F;
    localparam logic [4:0]  STEP_MAX_SHORT = 5'h0F;

    localparam int CHANNELS = 3;

    typedef struct packed {
        logic fine;
        logic coarse;
        logic level;
    } psg_chan_wr_t;

    typedef struct packed {
        logic period_lo;
        logic period_hi;
        logic shape;
        logic level;
    } psg_env_wr_t;

    function automatic logic [11:0] vol_lookup(input logic [3:0] idx);
        logic [11:0] v;
        case (idx)
            4'd0:    v = 12'd21;
            4'd1:    v = 12'd30;
            4'd2:    v = 12'd43;
            4'd3:    v = 12'd60;
            4'd4:    v = 12'd86;
            4'd5:    v = 12'd121;
            4'd6:    v = 12'd171;
            4'd7:    v = 12'd242;
            4'd8:    v = 12'd342;
            4'd9:    v = 12'd483;
            4'd10:   v = 12'd683;
            4'd11:   v = 12'd965;
            4'd12:   v = 12'd1363;
            4'd13:   v = 12'd1925;
            4'd14:   v = 12'd2718;
            default: v = 12'd3840;
        endcase
        return v;
    endfunction

    // lower half of the 32-step envelope curve
    function automatic logic [11:0] env_low_lookup(input logic [3:0] idx);
        logic [11:0] v;
        case (idx)
            4'd8, 4'd9: v = 12'd1;
            4'd10:      v = 12'd2;
            4'd11:      v = 12'd3;
            4'd12:      v = 12'd5;
            4'd13:      v = 12'd7;
            4'd14:      v = 12'd10;
            4'd15:      v = 12'd15;
            default:    v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] env_lookup(input logic [4:0] idx, input logic short_env);
        logic [11:0] v;
        if (short_env || idx[4])
            v = vol_lookup(idx[3:0]);
        else
            v = env_low_lookup(idx[3:0]);
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psg_tone_chan.sv =====
// one channel: tone divider, square phase and level register
`default_nettype none

module psg_tone_chan
    import psg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         tick,
    input  wire psg_chan_wr_t wr,
    input  wire logic [7:0]   data,
    output logic              phase,
    output logic [3:0]        volume,
    output logic              env_mode
);

    logic [11:0] period_raw_reg, period_raw_next;
    logic [15:0] count_reg, count_next;
    logic        phase_reg, phase_next;
    logic [3:0]  volume_reg, volume_next;
    logic        env_mode_reg, env_mode_next;

    logic [15:0] count_inc;
    logic [15:0] period_full;

    always_comb
    begin
        period_raw_next = period_raw_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        volume_next     = volume_reg;
        env_mode_next   = env_mode_reg;
        count_inc       = count_reg + 16'd1;
        period_full     = {1'b0, period_raw_reg, 3'b000};
        if (tick)
        begin
            count_next = count_inc;
            if (count_inc >= period_full)
            begin
                count_next = count_inc - period_full;
                phase_next = ~phase_reg;
            end
        end
        if (wr.fine)
            period_raw_next = {period_raw_reg[11:8], data};
        if (wr.coarse)
            period_raw_next = {data[3:0], period_raw_reg[7:0]};
        if (wr.level)
        begin
            volume_next   = data[3:0];
            env_mode_next = data[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_raw_reg <= '0;
            count_reg      <= '0;
            phase_reg      <= 1'b0;
            volume_reg     <= '0;
            env_mode_reg   <= 1'b0;
        end
        else
        begin
            period_raw_reg <= period_raw_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            volume_reg     <= volume_next;
            env_mode_reg   <= env_mode_next;
        end
    end

    assign phase    = phase_reg;
    assign volume   = volume_reg;
    assign env_mode = env_mode_reg;

endmodule

`default_nettype wire

// ===== rtl/psg_noise_gen.sv =====
// noise divider and 17-bit lfsr
`default_nettype none

module psg_noise_gen
    import psg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       tick,
    input  wire logic       wr_period,
    input  wire logic [7:0] data,
    output logic            noise_bit
);

    logic [4:0]  period_raw_reg, period_raw_next;
    logic [8:0]  count_reg, count_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic        out_reg, out_next;

    logic [8:0]  count_inc;
    logic [8:0]  period_full;

    always_comb
    begin
        period_raw_next = period_raw_reg;
        count_next      = count_reg;
        lfsr_next       = lfsr_reg;
        out_next        = out_reg;
        count_inc       = count_reg + 9'd1;
        period_full     = {1'b0, period_raw_reg, 3'b000};
        if (tick)
        begin
            count_next = count_inc;
            if (count_inc >= period_full)
            begin
                count_next = count_inc - period_full;
                out_next   = lfsr_reg[0];
                lfsr_next  = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
            end
        end
        if (wr_period)
            period_raw_next = data[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_raw_reg <= '0;
            count_reg      <= '0;
            lfsr_reg       <= NOISE_SEED;
            out_reg        <= 1'b0;
        end
        else
        begin
            period_raw_reg <= period_raw_next;
            count_reg      <= count_next;
            lfsr_reg       <= lfsr_next;
            out_reg        <= out_next;
        end
    end

    assign noise_bit = out_reg;

endmodule

`default_nettype wire

// ===== rtl/psg_env_gen.sv =====
// envelope generator: period divider, step counter, attack/alternate/hold
`default_nettype none

module psg_env_gen
    import psg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tick,
    input  wire psg_env_wr_t wr,
    input  wire logic [7:0]  data,
    input  wire logic        short_env,
    input  wire logic        any_env_mode,
    output logic [11:0]      level
);

    logic [15:0] raw_reg, raw_next;
    logic [20:0] count_reg, count_next;
    logic [4:0]  step_reg, step_next;
    logic [4:0]  attack_reg, attack_next;
    logic [4:0]  hold_reg, hold_next;
    logic [4:0]  alt_reg, alt_next;
    logic        held_reg, held_next;
    logic        halted_reg, halted_next;
    logic [11:0] level_reg, level_next;

    logic [4:0]  step_max;
    logic [19:0] period;
    logic [20:0] count_inc;
    logic [4:0]  shape_attack;

    always_comb
    begin
        raw_next    = raw_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        attack_next = attack_reg;
        hold_next   = hold_reg;
        alt_next    = alt_reg;
        held_next   = held_reg;
        halted_next = halted_reg;
        level_next  = level_reg;

        step_max     = short_env ? STEP_MAX_SHORT : STEP_MAX_LONG;
        period       = short_env ? {raw_reg, 4'b0000} : {1'b0, raw_reg, 3'b000};
        count_inc    = count_reg + 21'd1;
        shape_attack = data[2] ? step_max : 5'd0;

        if (tick && !halted_reg)
        begin
            count_next = count_inc;
            if (count_inc >= {1'b0, period})
            begin
                count_next = count_inc - {1'b0, period};
                if (step_reg == 5'd0)
                begin
                    attack_next = attack_reg ^ alt_reg;
                    step_next   = hold_reg ^ step_max;
                    held_next   = (hold_reg != 5'd0);
                    halted_next = (hold_reg != 5'd0) || !any_env_mode;
                end
                else
                begin
                    step_next = step_reg - 5'd1;
                end
                level_next = env_lookup(step_next ^ attack_next, short_env);
            end
        end

        if (wr.period_lo)
            raw_next = {raw_reg[15:8], data};
        if (wr.period_hi)
            raw_next = {data, raw_reg[7:0]};
        if (wr.level)
            halted_next = held_reg || !any_env_mode;
        if (wr.shape)
        begin
            attack_next = shape_attack;
            if (data[3])
            begin
                hold_next = data[0] ? step_max : 5'd0;
                alt_next  = data[1] ? step_max : 5'd0;
            end
            else
            begin
                hold_next = step_max;
                alt_next  = shape_attack;
            end
            step_next   = step_max;
            level_next  = env_lookup(shape_attack ^ step_max, short_env);
            held_next   = 1'b0;
            halted_next = !any_env_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
            attack_reg <= '0;
            hold_reg   <= '0;
            alt_reg    <= '0;
            held_reg   <= 1'b0;
            halted_reg <= 1'b1;
            level_reg  <= '0;
        end
        else
        begin
            raw_reg    <= raw_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            attack_reg <= attack_next;
            hold_reg   <= hold_next;
            alt_reg    <= alt_next;
            held_reg   <= held_next;
            halted_reg <= halted_next;
            level_reg  <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// ===== rtl/psg_tone_noise_envelope_core.sv =====
// three-channel sound generator: tone dividers, noise lfsr and envelope
//
// usage:
//   s_axis carries one item per transaction: tuser is the command (0 = tick,
//   1 = register write), tdata holds the register address and data byte.
//   m_axis returns exactly one result per item: tone phases, noise bit, mixer
//   masks, three channel amplitudes and the envelope level, all taken from
//   the generator state after that item.
//   cfg_valid/cfg_ready/cfg_data writes the short envelope mode bit; write it
//   only while no item is in flight.
// timing:
//   an item is captured in the input register, then applied to the generator
//   state once no result waits or m_axis_tready is high; the updated state
//   is presented as its result. one item per cycle is sustained while
//   m_axis_tready stays high.
// reset and stall:
//   rst_n clears all but input data registers (noise lfsr to seed, envelope
//   halted). a result waiting with m_axis_tready low holds, as does the state;
//   s_axis_tready stays high until the input register is also occupied.
`default_nettype none

module psg_tone_noise_envelope_core
    import psg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // reg_addr[3:0], reg_data[11:4], zero
    input  wire logic        s_axis_tuser,  // cmd[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tone_phase_a[0], tone_phase_b[1], tone_phase_c[2], noise_bit[3],
    // tone_disable_mask[6:4], noise_disable_mask[9:7], amplitude_a[21:10],
    // amplitude_b[33:22], amplitude_c[45:34], envelope_level[57:46], zero
    output logic [63:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    logic        in_valid_reg, in_valid_next;
    logic        in_cmd_reg;
    logic [3:0]  in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic        short_env_reg;
    logic [5:0]  mixer_reg, mixer_next;

    logic        advance;
    logic        tick;
    logic        wr;
    psg_chan_wr_t chan_wr [CHANNELS];
    psg_env_wr_t  env_wr;
    logic        noise_wr;
    logic        mixer_wr;

    logic [CHANNELS-1:0] phase;
    logic [CHANNELS-1:0] env_mode;
    logic [CHANNELS-1:0] env_mode_after;
    logic [3:0]          volume [CHANNELS];
    logic [11:0]         amplitude [CHANNELS];
    logic [11:0]         env_level;
    logic                noise_bit;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign tick          = advance && (in_cmd_reg == CMD_TICK);
    assign wr            = advance && (in_cmd_reg == CMD_WRITE);

    // address decode of a write transaction
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            chan_wr[i] = '0;
        env_wr   = '0;
        noise_wr = 1'b0;
        mixer_wr = 1'b0;
        if (wr)
        begin
            unique case (in_addr_reg)
                ADDR_TONE_FINE_A:   chan_wr[0].fine   = 1'b1;
                ADDR_TONE_COARSE_A: chan_wr[0].coarse = 1'b1;
                ADDR_TONE_FINE_B:   chan_wr[1].fine   = 1'b1;
                ADDR_TONE_COARSE_B: chan_wr[1].coarse = 1'b1;
                ADDR_TONE_FINE_C:   chan_wr[2].fine   = 1'b1;
                ADDR_TONE_COARSE_C: chan_wr[2].coarse = 1'b1;
                ADDR_NOISE_PERIOD:  noise_wr          = 1'b1;
                ADDR_MIXER:         mixer_wr          = 1'b1;
                ADDR_LEVEL_A:       chan_wr[0].level  = 1'b1;
                ADDR_LEVEL_B:       chan_wr[1].level  = 1'b1;
                ADDR_LEVEL_C:       chan_wr[2].level  = 1'b1;
                ADDR_ENV_LO:        env_wr.period_lo  = 1'b1;
                ADDR_ENV_HI:        env_wr.period_hi  = 1'b1;
                ADDR_ENV_SHAPE:     env_wr.shape      = 1'b1;
                default:            ;
            endcase
            env_wr.level = chan_wr[0].level || chan_wr[1].level || chan_wr[2].level;
        end
    end

    // envelope modes as they stand once this item is applied
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            env_mode_after[i] = chan_wr[i].level ? in_data_reg[4] : env_mode[i];
    end

    assign mixer_next     = mixer_wr ? in_data_reg[5:0] : mixer_reg;
    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            short_env_reg <= 1'b0;
            mixer_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mixer_reg     <= mixer_next;
            if (cfg_valid && cfg_ready)
                short_env_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[3:0];
            in_data_reg <= s_axis_tdata[11:4];
        end
    end

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        psg_tone_chan u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (tick),
            .wr       (chan_wr[g]),
            .data     (in_data_reg),
            .phase    (phase[g]),
            .volume   (volume[g]),
            .env_mode (env_mode[g])
        );

        assign amplitude[g] = env_mode[g] ? env_level : vol_lookup(volume[g]);
    end

    psg_noise_gen u_noise (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .wr_period (noise_wr),
        .data      (in_data_reg),
        .noise_bit (noise_bit)
    );

    psg_env_gen u_env (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .wr           (env_wr),
        .data         (in_data_reg),
        .short_env    (short_env_reg),
        .any_env_mode (|env_mode_after),
        .level        (env_level)
    );

    // generator state only moves on advance, so it doubles as the result register
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, env_level, amplitude[2], amplitude[1], amplitude[0],
                            mixer_reg[5:3], mixer_reg[2:0], noise_bit, phase[2], phase[1],
                            phase[0]};

endmodule

`default_nettype wire

// ===== rtl/psg_checker.sv =====
// port-level checks for the sound generator core, bound to the top level
`default_nettype none

module psg_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input backpressure only when the result side is stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // a transaction accepted while no result is waiting yields a result after the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result missing after accepted transaction");

    // levels never exceed the top of the table and padding stays zero
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:10] <= 12'd3840 && m_axis_tdata[33:22] <= 12'd3840
            && m_axis_tdata[45:34] <= 12'd3840 && m_axis_tdata[57:46] <= 12'd3840
            && m_axis_tdata[63:58] == 6'd0)
        else $error("level out of range");

endmodule

bind psg_tone_noise_envelope_core psg_checker u_psg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
